// File: hw/rtl/lkvc_pkg.sv
// Shared types and codes for the LRU key-value cache.
`default_nettype none

package lkvc_pkg;

   // Width of the configuration register.
   localparam int CapWidth = 5;

   // Capacity register value after reset.
   localparam logic [CapWidth-1:0] CapReset = 5'd16;

   // Action codes of a request beat.
   localparam logic ACTION_GET = 1'b0;
   localparam logic ACTION_PUT = 1'b1;

   // One request beat.
   typedef struct packed {
      logic        action;
      logic [31:0] key;
      logic [31:0] value;
   } lkvc_req_type;

   // One response beat.
   typedef struct packed {
      logic        hit;
      logic [31:0] read_value;
   } lkvc_rsp_type;

   // Update command broadcast from the controller to every cell.
   typedef struct packed {
      logic en;     // apply an update in this cycle
      logic hit;    // the key was found in some cell
      logic write;  // the access is a put
      logic fill;   // a miss put goes to a free slot rather than the victim
   } lkvc_ctl_type;

endpackage

`default_nettype wire

// File: hw/rtl/lru_key_value_cache.sv
// Top level of the LRU key-value cache: controller and row of storage cells.
//
//   Channel  Ports                            Direction  Moves
//   req      req_valid req_ready req_data     in         get or put beat
//   rsp      rsp_valid rsp_ready rsp_data     out        hit flag and read value
//   csr      csr_write_enable csr_write_data  in         capacity_in_use write
//
// Each request runs in order: the accept edge registers the key compare in
// every cell; in the update cycle the match chain is merged across the row, and
// the edge that closes it updates the ranks and loads the response register.
// A full response register that is not taken stalls the update cycle.
// Reset clears valid bits, ranks and the fill count at once; no clearing pass.
`default_nettype none

module lru_key_value_cache #(
   parameter int CAPACITY    = 16,
   parameter int KEY_WIDTH   = 32,
   parameter int VALUE_WIDTH = 32
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_valid,
   output logic                        req_ready,
   input  wire lkvc_pkg::lkvc_req_type req_data,
   output logic                        rsp_valid,
   input  wire logic                   rsp_ready,
   output lkvc_pkg::lkvc_rsp_type      rsp_data,
   input  wire logic                   csr_write_enable,
   input  wire logic [lkvc_pkg::CapWidth-1:0] csr_write_data
);
   import lkvc_pkg::*;

   localparam int KEY_W   = (KEY_WIDTH < 32) ? KEY_WIDTH : 32;
   localparam int VALUE_W = (VALUE_WIDTH < 32) ? VALUE_WIDTH : 32;
   localparam int RANK_W  = $clog2(CAPACITY);
   localparam int CNT_W   = $clog2(CAPACITY + 1);
   localparam int CMP_W   = (CNT_W > CapWidth) ? CNT_W : CapWidth;

   typedef enum logic {
      IDLE,
      UPDATE
   } state_type;

   state_type          state_ff;
   logic               rsp_valid_ff;
   lkvc_rsp_type       rsp_data_ff;
   logic               action_ff;
   logic [KEY_W-1:0]   key_ff;
   logic [VALUE_W-1:0] value_ff;
   logic [CapWidth-1:0] cap_ff;
   logic [CNT_W-1:0]   used_ff;

   logic               accept;
   logic               out_free;
   logic               update_go;
   logic [CMP_W-1:0]   cap_ext;
   logic [CMP_W-1:0]   cap_eff;
   logic               fill;
   logic [RANK_W:0]    age_limit;
   lkvc_ctl_type       ctl;

   logic               chain_hit   [0:CAPACITY];
   logic [RANK_W-1:0]  chain_rank  [0:CAPACITY];
   logic [VALUE_W-1:0] chain_value [0:CAPACITY];

   assign req_ready = (state_ff == IDLE);
   assign accept    = req_valid && req_ready;
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign update_go = (state_ff == UPDATE) && out_free;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // Effective capacity: zero acts as one, values above the row size clip.
   assign cap_ext = CMP_W'(cap_ff);
   always_comb begin
      if (cap_ext == '0) begin
         cap_eff = CMP_W'(1);
      end else if (cap_ext > CMP_W'(CAPACITY)) begin
         cap_eff = CMP_W'(CAPACITY);
      end else begin
         cap_eff = cap_ext;
      end
   end
   assign fill = (CMP_W'(used_ff) < cap_eff);

   // Command broadcast to the cells in the update cycle.
   assign ctl.hit   = chain_hit[CAPACITY];
   assign ctl.write = (action_ff == ACTION_PUT);
   assign ctl.fill  = fill;
   assign ctl.en    = update_go && (ctl.write || ctl.hit);

   // Entries below this rank age by one; a fill ages every valid entry.
   always_comb begin
      if (ctl.hit) begin
         age_limit = {1'b0, chain_rank[CAPACITY]};
      end else if (fill) begin
         age_limit = (RANK_W + 1)'(CAPACITY);
      end else begin
         age_limit = (RANK_W + 1)'(used_ff - CNT_W'(1));
      end
   end

   // Head of the match chain.
   assign chain_hit[0]   = 1'b0;
   assign chain_rank[0]  = '0;
   assign chain_value[0] = '0;

   // Row of storage cells.
   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      lkvc_cell #(
         .INDEX   (i),
         .KEY_W   (KEY_W),
         .VALUE_W (VALUE_W),
         .RANK_W  (RANK_W),
         .CNT_W   (CNT_W)
      ) u_cell (
         .clock     (clock),
         .reset     (reset),
         .accept    (accept),
         .req_key   (req_data.key[KEY_W-1:0]),
         .ctl       (ctl),
         .upd_key   (key_ff),
         .upd_value (value_ff),
         .age_limit (age_limit),
         .used      (used_ff),
         .hit_in    (chain_hit[i]),
         .rank_in   (chain_rank[i]),
         .value_in  (chain_value[i]),
         .hit_out   (chain_hit[i+1]),
         .rank_out  (chain_rank[i+1]),
         .value_out (chain_value[i+1])
      );
   end

   // Request holding register.
   always_ff @(posedge clock) begin
      if (accept) begin
         action_ff <= req_data.action;
         key_ff    <= req_data.key[KEY_W-1:0];
         value_ff  <= req_data.value[VALUE_W-1:0];
      end
   end

   // Capacity register.
   always_ff @(posedge clock) begin
      if (reset) begin
         cap_ff <= CapReset;
      end else if (csr_write_enable) begin
         cap_ff <= csr_write_data;
      end
   end

   // Fill count grows on each put of a new key into a free slot.
   always_ff @(posedge clock) begin
      if (reset) begin
         used_ff <= '0;
      end else if (ctl.en && !ctl.hit && fill) begin
         used_ff <= used_ff + CNT_W'(1);
      end
   end

   // Controller state and response register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         unique case (state_ff)
            IDLE: begin
               if (rsp_valid_ff && rsp_ready) begin
                  rsp_valid_ff <= 1'b0;
               end
               if (accept) begin
                  state_ff <= UPDATE;
               end
            end
            UPDATE: begin
               if (out_free) begin
                  state_ff             <= IDLE;
                  rsp_valid_ff         <= 1'b1;
                  rsp_data_ff.hit      <= chain_hit[CAPACITY];
                  rsp_data_ff.read_value <= (chain_hit[CAPACITY] && !ctl.write) ?
                                            32'(chain_value[CAPACITY]) : 32'd0;
               end
            end
            default: begin
               state_ff <= IDLE;
            end
         endcase
      end
   end

`ifndef ASSERT_OFF
   // The fill count never passes the number of cells.
   assert property (@(posedge clock) disable iff (reset)
      CMP_W'(used_ff) <= CMP_W'(CAPACITY))
      else $error("fill count exceeds the number of cells");

   // An accepted beat is always followed by an update cycle.
   assert property (@(posedge clock) disable iff (reset)
      accept |=> (state_ff == UPDATE))
      else $error("accepted beat did not enter the update cycle");

   // A response appears only out of an update cycle.
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == UPDATE))
      else $error("response raised outside an update cycle");

   // The fill count moves by at most one per cycle.
   assert property (@(posedge clock) disable iff (reset)
      ($past(used_ff) != used_ff) |-> (used_ff == $past(used_ff) + CNT_W'(1)))
      else $error("fill count moved by more than one");

   // A new response is never loaded while the previous one waits.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_ready) |=> $stable(rsp_data_ff))
      else $error("pending response overwritten");
`endif

endmodule

`default_nettype wire

// File: hw/rtl/lkvc_cell.sv
// One storage cell of the LRU cache: key, value, valid bit and recency rank.
`default_nettype none

module lkvc_cell #(
   parameter int INDEX   = 0,
   parameter int KEY_W   = 32,
   parameter int VALUE_W = 32,
   parameter int RANK_W  = 4,
   parameter int CNT_W   = 5
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 accept,
   input  wire logic [KEY_W-1:0]     req_key,
   input  wire lkvc_pkg::lkvc_ctl_type ctl,
   input  wire logic [KEY_W-1:0]     upd_key,
   input  wire logic [VALUE_W-1:0]   upd_value,
   input  wire logic [RANK_W:0]      age_limit,
   input  wire logic [CNT_W-1:0]     used,
   input  wire logic                 hit_in,
   input  wire logic [RANK_W-1:0]    rank_in,
   input  wire logic [VALUE_W-1:0]   value_in,
   output logic                      hit_out,
   output logic [RANK_W-1:0]         rank_out,
   output logic [VALUE_W-1:0]        value_out
);
   import lkvc_pkg::*;

   logic [KEY_W-1:0]   key_ff;
   logic [VALUE_W-1:0] value_ff;
   logic               valid_ff;
   logic [RANK_W-1:0]  rank_ff;
   logic               match_ff;
   logic               is_fill_slot;
   logic               is_victim;
   logic               target;
   logic               ages;

   // Merge this cell's match into the chain passed down the row.
   assign hit_out   = hit_in | match_ff;
   assign rank_out  = rank_in | (match_ff ? rank_ff : '0);
   assign value_out = value_in | (match_ff ? value_ff : '0);

   // Valid slots always form a prefix, so the free slot is the one at the fill count.
   assign is_fill_slot = (used == CNT_W'(INDEX));
   // The least recent entry holds the highest rank, one below the fill count.
   assign is_victim    = valid_ff && (CNT_W'(rank_ff) == (used - CNT_W'(1)));
   assign target       = ctl.hit ? match_ff : (ctl.fill ? is_fill_slot : is_victim);
   assign ages         = valid_ff && ({1'b0, rank_ff} < age_limit);

   // Key compare is registered when the request beat is accepted.
   always_ff @(posedge clock) begin
      if (reset) begin
         match_ff <= 1'b0;
      end else if (accept) begin
         match_ff <= valid_ff && (key_ff == req_key);
      end
   end

   // Valid bit and rank carry reset; key and value are written before use.
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         rank_ff  <= '0;
      end else if (ctl.en) begin
         if (target) begin
            rank_ff <= '0;
            if (ctl.write && !ctl.hit) begin
               valid_ff <= 1'b1;
            end
         end else if (ages) begin
            rank_ff <= rank_ff + RANK_W'(1);
         end
      end
   end

   // Payload storage.
   always_ff @(posedge clock) begin
      if (ctl.en && target && ctl.write) begin
         value_ff <= upd_value;
         if (!ctl.hit) begin
            key_ff <= upd_key;
         end
      end
   end

endmodule

`default_nettype wire
